### hw/rtl/gds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gds_pkg
// shared types, operation codes, status codes and the month length table
// for the gregorian date stepper
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OP_W    = 4;
    localparam int STAT_W  = 2;
    localparam int QUO_W   = 10;

    localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd0;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // floor(y / 25) = (y * 5243) >> 17 for every 14 bit y
    localparam logic [12:0] RECIP_25   = 13'd5243;
    localparam int          RECIP_SHFT = 17;

    localparam logic [OP_W-1:0] OP_NEXT_DAY     = 4'd0;
    localparam logic [OP_W-1:0] OP_PREV_DAY     = 4'd1;
    localparam logic [OP_W-1:0] OP_NEXT_MBEGIN  = 4'd2;
    localparam logic [OP_W-1:0] OP_PREV_MBEGIN  = 4'd3;
    localparam logic [OP_W-1:0] OP_NEXT_MEND    = 4'd4;
    localparam logic [OP_W-1:0] OP_PREV_MEND    = 4'd5;
    localparam logic [OP_W-1:0] OP_NEXT_WEEK    = 4'd6;
    localparam logic [OP_W-1:0] OP_PREV_WEEK    = 4'd7;
    localparam logic [OP_W-1:0] OP_SNAP_MEND_UP = 4'd8;
    localparam logic [OP_W-1:0] OP_SNAP_MEND_DN = 4'd9;
    localparam logic [OP_W-1:0] OP_SNAP_MBEG_UP = 4'd10;
    localparam logic [OP_W-1:0] OP_SNAP_MBEG_DN = 4'd11;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_DATE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [YEAR_W-1:0]  year_in;
        logic [MONTH_W-1:0] month_in;
        logic [DAY_W-1:0]   day_in;
    } gds_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year_out;
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
        logic [STAT_W-1:0]  status;
    } gds_rsp_t;

    // after the first stage: request and year / 25
    typedef struct packed {
        gds_req_t          req;
        logic [QUO_W-1:0]  quo25;
    } gds_div_t;

    // after the second stage: request, month lengths and neighbor months
    typedef struct packed {
        gds_req_t           req;
        logic               invalid;
        logic [MONTH_W-1:0] month_prev;
        logic [MONTH_W-1:0] month_next;
        logic [DAY_W-1:0]   len_cur;
        logic [DAY_W-1:0]   len_prev;
        logic [DAY_W-1:0]   len_next;
    } gds_cal_t;

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/gds_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gds_div
// first pipeline stage: year divided by 25 through a reciprocal multiply
// ----------------------------------------------------------------------------
module gds_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gds_pkg::gds_req_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gds_pkg::gds_div_t      out_data
);
    import gds_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    gds_div_t           data_reg;
    gds_div_t           data_next;
    logic [26:0]        prod;

    assign in_ready = !valid_reg || out_ready;
    assign prod     = {13'd0, in_data.year_in} * {14'd0, RECIP_25};

    always_comb begin
        valid_next      = in_ready ? in_valid : valid_reg;
        data_next.req   = in_data;
        data_next.quo25 = prod[RECIP_SHFT +: QUO_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

### hw/rtl/gds_cal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gds_cal
// second pipeline stage: leap year, month lengths, neighbor months and
// input date check
// ----------------------------------------------------------------------------
module gds_cal (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gds_pkg::gds_div_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gds_pkg::gds_cal_t      out_data
);
    import gds_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    gds_cal_t           data_reg;
    gds_cal_t           data_next;
    logic [YEAR_W-1:0]  times25;
    logic               div25;
    logic               leap;
    logic [YEAR_W-1:0]  yr;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   dy;

    assign in_ready = !valid_reg || out_ready;

    assign yr      = in_data.req.year_in;
    assign mo      = in_data.req.month_in;
    assign dy      = in_data.req.day_in;
    assign times25 = {in_data.quo25, 4'd0} + {1'b0, in_data.quo25, 3'd0}
                   + {4'd0, in_data.quo25};
    assign div25   = (times25 == yr);
    // divisible by 4 and not by 100, or by 400 (16 and 25)
    assign leap    = (yr[1:0] == 2'd0) && (!div25 || (yr[3:0] == 4'd0));

    always_comb begin
        valid_next           = in_ready ? in_valid : valid_reg;
        data_next.req        = in_data.req;
        data_next.month_prev = (mo == MONTH_JAN) ? MONTH_DEC : mo - 4'd1;
        data_next.month_next = (mo == MONTH_DEC) ? MONTH_JAN : mo + 4'd1;
        data_next.len_cur    = month_length(mo, leap);
        data_next.len_prev   = month_length(data_next.month_prev, leap);
        data_next.len_next   = month_length(data_next.month_next, leap);
        data_next.invalid    = (yr > YEAR_MAX) || (mo == 4'd0) || (mo > MONTH_DEC)
                             || (dy == 5'd0) || (dy > data_next.len_cur);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

### hw/rtl/gds_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gds_step
// third pipeline stage: applies the operation, checks the year range and
// holds the result in the output register
// ----------------------------------------------------------------------------
module gds_step (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gds_pkg::gds_cal_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gds_pkg::gds_rsp_t      out_data
);
    import gds_pkg::*;

    localparam logic [1:0] DIR_SAME = 2'd0;
    localparam logic [1:0] DIR_NEXT = 2'd1;
    localparam logic [1:0] DIR_PREV = 2'd2;

    logic               valid_reg;
    logic               valid_next;
    gds_rsp_t           data_reg;
    gds_rsp_t           data_next;
    logic [1:0]         dir;
    logic [DAY_W-1:0]   day_new;
    logic [DAY_W-1:0]   dy;
    logic [MONTH_W-1:0] mo;
    logic [YEAR_W-1:0]  yr;
    logic [DAY_W:0]     fwd7;
    logic [DAY_W:0]     back7;
    logic               fwd_wrap;
    logic               back_wrap;
    logic               year_up;
    logic               year_dn;
    logic               out_of_range;

    assign in_ready = !valid_reg || out_ready;

    assign dy = in_data.req.day_in;
    assign mo = in_data.req.month_in;
    assign yr = in_data.req.year_in;

    assign fwd7      = {1'b0, dy} + 6'd7;
    assign fwd_wrap  = fwd7 > {1'b0, in_data.len_cur};
    assign back_wrap = dy <= 5'd7;
    assign back7     = back_wrap ? ({1'b0, dy} + {1'b0, in_data.len_prev} - 6'd7)
                                 : ({1'b0, dy} - 6'd7);

    always_comb begin
        dir     = DIR_SAME;
        day_new = dy;
        case (in_data.req.op)
            OP_NEXT_DAY: begin
                if (dy < in_data.len_cur) begin
                    day_new = dy + 5'd1;
                end else begin
                    dir     = DIR_NEXT;
                    day_new = 5'd1;
                end
            end
            OP_PREV_DAY: begin
                if (dy > 5'd1) begin
                    day_new = dy - 5'd1;
                end else begin
                    dir     = DIR_PREV;
                    day_new = in_data.len_prev;
                end
            end
            OP_NEXT_MBEGIN: begin
                dir     = DIR_NEXT;
                day_new = 5'd1;
            end
            OP_PREV_MBEGIN: begin
                dir     = DIR_PREV;
                day_new = 5'd1;
            end
            OP_NEXT_MEND: begin
                dir     = DIR_NEXT;
                day_new = in_data.len_next;
            end
            OP_PREV_MEND: begin
                dir     = DIR_PREV;
                day_new = in_data.len_prev;
            end
            OP_NEXT_WEEK: begin
                if (fwd_wrap) begin
                    dir     = DIR_NEXT;
                    day_new = DAY_W'(fwd7 - {1'b0, in_data.len_cur});
                end else begin
                    day_new = fwd7[DAY_W-1:0];
                end
            end
            OP_PREV_WEEK: begin
                dir     = back_wrap ? DIR_PREV : DIR_SAME;
                day_new = back7[DAY_W-1:0];
            end
            OP_SNAP_MEND_UP: begin
                day_new = in_data.len_cur;
            end
            OP_SNAP_MEND_DN: begin
                if (dy != in_data.len_cur) begin
                    dir     = DIR_PREV;
                    day_new = in_data.len_prev;
                end
            end
            OP_SNAP_MBEG_UP: begin
                if (dy != 5'd1) begin
                    dir     = DIR_NEXT;
                    day_new = 5'd1;
                end
            end
            OP_SNAP_MBEG_DN: begin
                day_new = 5'd1;
            end
            default: begin
                dir     = DIR_SAME;
                day_new = dy;
            end
        endcase
    end

    assign year_up      = (dir == DIR_NEXT) && (mo == MONTH_DEC);
    assign year_dn      = (dir == DIR_PREV) && (mo == MONTH_JAN);
    assign out_of_range = (year_up && (yr == YEAR_MAX)) || (year_dn && (yr == YEAR_MIN));

    always_comb begin
        valid_next         = in_ready ? in_valid : valid_reg;
        data_next.year_out = yr;
        data_next.month_out = mo;
        data_next.day_out  = dy;
        data_next.status   = ST_OK;
        if (in_data.invalid) begin
            data_next.status = ST_BAD_DATE;
        end else if (out_of_range) begin
            data_next.status = ST_RANGE;
        end else begin
            data_next.day_out = day_new;
            case (dir)
                DIR_NEXT: begin
                    data_next.month_out = in_data.month_next;
                    data_next.year_out  = year_up ? yr + 14'd1 : yr;
                end
                DIR_PREV: begin
                    data_next.month_out = in_data.month_prev;
                    data_next.year_out  = year_dn ? yr - 14'd1 : yr;
                end
                default: begin
                    data_next.month_out = mo;
                    data_next.year_out  = yr;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

### hw/rtl/gregorian_date_stepper_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_stepper_core
// steps a proleptic gregorian date by day, week or month, or snaps it to a
// month begin or end
// ----------------------------------------------------------------------------
// Each request carries an operation and a date; each gives exactly one
// response with the stepped date and a status (ok, invalid input date, or
// result year outside 0..9999, the last two echoing the input date). The
// block is a three stage pipeline (divide by 25, month lengths and date
// check, operation and output register) and takes one request every cycle
// while it is not stalled; each stage registers its result. While m_ready
// is low the stages fill and s_ready drops only once all three hold data.
module gregorian_date_stepper_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire gds_pkg::gds_req_t s_req,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output gds_pkg::gds_rsp_t      m_rsp
);
    import gds_pkg::*;

    logic     div_valid;
    logic     div_ready;
    gds_div_t div_data;
    logic     cal_valid;
    logic     cal_ready;
    gds_cal_t cal_data;

    gds_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_req),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    gds_cal u_cal (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (cal_valid),
        .out_ready (cal_ready),
        .out_data  (cal_data)
    );

    gds_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cal_valid),
        .in_ready  (cal_ready),
        .in_data   (cal_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_rsp)
    );

    // backpressure reaches the input only when every stage is full
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && div_valid && cal_valid))
        else $error("input stalled with an empty stage");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid right after reset");

    a_ok_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == ST_OK) |->
        (m_rsp.year_out <= YEAR_MAX && m_rsp.month_out >= MONTH_JAN
         && m_rsp.month_out <= MONTH_DEC && m_rsp.day_out != 5'd0))
        else $error("ok response with a malformed date");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.status == ST_OK || m_rsp.status == ST_BAD_DATE
                     || m_rsp.status == ST_RANGE))
        else $error("response status code unknown");

    a_feb_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rsp.status == ST_OK && m_rsp.month_out == MONTH_FEB) |->
        (m_rsp.day_out <= 5'd29))
        else $error("ok response past end of february");

endmodule
`default_nettype wire

### verif/gregorian_date_stepper_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_stepper_core_tb
// self-checking bench: directed corner dates, then random dates and ops
// under bursty requests and a stalling response side; every response is
// compared field by field against a date stepping model kept in a scoreboard
// ----------------------------------------------------------------------------
module gregorian_date_stepper_core_tb;

    import gds_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd12;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
    localparam int RANDOM_REQS  = 525;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT_RSP  = 150;
    localparam int DRAIN_AT_REQ = 300;

    class date_scoreboard;
        typedef struct {
            int y;
            int m;
            int d;
        } ymd_t;

        gds_rsp_t expected_q[$];
        int       errors = 0;

        static function bit is_leap(int y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        static function int days_in(int y, int m);
            case (m)
                2:          return is_leap(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:    return 31;
            endcase
        endfunction

        function ymd_t begin_after(ymd_t t);
            t.d = 1;
            if (t.m == 12) begin
                t.y = t.y + 1;
                t.m = 1;
            end else begin
                t.m = t.m + 1;
            end
            return t;
        endfunction

        function ymd_t begin_before(ymd_t t);
            t.d = 1;
            if (t.m == 1) begin
                t.y = t.y - 1;
                t.m = 12;
            end else begin
                t.m = t.m - 1;
            end
            return t;
        endfunction

        function ymd_t end_after(ymd_t t);
            if (t.m == 12) begin
                t.y = t.y + 1;
                t.m = 1;
                t.d = 31;
            end else begin
                t.m = t.m + 1;
                t.d = days_in(t.y, t.m);
            end
            return t;
        endfunction

        function ymd_t end_before(ymd_t t);
            if (t.m == 1) begin
                t.y = t.y - 1;
                t.m = 12;
                t.d = 31;
            end else begin
                t.m = t.m - 1;
                t.d = days_in(t.y, t.m);
            end
            return t;
        endfunction

        function ymd_t day_forward(ymd_t t);
            if (t.d < days_in(t.y, t.m)) begin
                t.d = t.d + 1;
                return t;
            end
            return begin_after(t);
        endfunction

        function ymd_t day_backward(ymd_t t);
            if (t.d > 1) begin
                t.d = t.d - 1;
                return t;
            end
            return end_before(t);
        endfunction

        function gds_rsp_t step_date(gds_req_t r);
            ymd_t              t;
            logic [STAT_W-1:0] st;
            gds_rsp_t          rsp;
            t.y = r.year_in;
            t.m = r.month_in;
            t.d = r.day_in;
            st  = ST_OK;
            if (r.year_in > YEAR_MAX || r.month_in < MONTH_JAN || r.month_in > MONTH_DEC ||
                r.day_in < 1 || r.day_in > days_in(t.y, t.m)) begin
                st = ST_BAD_DATE;
            end else begin
                case (r.op)
                    OP_NEXT_DAY:     t = day_forward(t);
                    OP_PREV_DAY:     t = day_backward(t);
                    OP_NEXT_MBEGIN:  t = begin_after(t);
                    OP_PREV_MBEGIN:  t = begin_before(t);
                    OP_NEXT_MEND:    t = end_after(t);
                    OP_PREV_MEND:    t = end_before(t);
                    OP_NEXT_WEEK:    for (int k = 0; k < 7; k++) t = day_forward(t);
                    OP_PREV_WEEK:    for (int k = 0; k < 7; k++) t = day_backward(t);
                    OP_SNAP_MEND_UP: t.d = days_in(t.y, t.m);
                    OP_SNAP_MEND_DN: if (t.d != days_in(t.y, t.m)) t = end_before(t);
                    OP_SNAP_MBEG_UP: if (t.d != 1) t = begin_after(t);
                    OP_SNAP_MBEG_DN: t.d = 1;
                    default: ;
                endcase
                if (t.y < 0 || t.y > 9999) st = ST_RANGE;
            end
            if (st != ST_OK) begin
                rsp.year_out  = r.year_in;
                rsp.month_out = r.month_in;
                rsp.day_out   = r.day_in;
            end else begin
                rsp.year_out  = YEAR_W'(t.y);
                rsp.month_out = MONTH_W'(t.m);
                rsp.day_out   = DAY_W'(t.d);
            end
            rsp.status = st;
            return rsp;
        endfunction

        function void note_request(gds_req_t r);
            expected_q.push_back(step_date(r));
        endfunction

        function void check_response(gds_rsp_t got);
            gds_rsp_t exp_rsp;
            if (expected_q.size() == 0) begin
                $error("response with no request outstanding: %p", got);
                errors++;
                return;
            end
            exp_rsp = expected_q.pop_front();
            if (got.year_out !== exp_rsp.year_out) begin
                $error("year_out expected %0d actual %0d", exp_rsp.year_out, got.year_out);
                errors++;
            end
            if (got.month_out !== exp_rsp.month_out) begin
                $error("month_out expected %0d actual %0d", exp_rsp.month_out, got.month_out);
                errors++;
            end
            if (got.day_out !== exp_rsp.day_out) begin
                $error("day_out expected %0d actual %0d", exp_rsp.day_out, got.day_out);
                errors++;
            end
            if (got.status !== exp_rsp.status) begin
                $error("status expected %0d actual %0d", exp_rsp.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    gds_req_t s_req   = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    gds_rsp_t m_rsp;

    date_scoreboard sb = new();
    int             cycle_count = 0;

    gregorian_date_stepper_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[gregorian_date_stepper_core] ERROR");
            $finish;
        end
    end

    function automatic gds_req_t make_req(logic [OP_W-1:0] op, int y, int m, int d);
        gds_req_t r;
        r.op       = op;
        r.year_in  = YEAR_W'(y);
        r.month_in = MONTH_W'(m);
        r.day_in   = DAY_W'(d);
        return r;
    endfunction

    function automatic gds_req_t random_req();
        gds_req_t r;
        int       kind;
        int       sel;
        int       y;
        int       m;
        int       d;
        int       len;
        kind = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        case (sel)
            0:       y = $urandom_range(0, 3);
            1:       y = $urandom_range(9996, 9999);
            2:       y = 100 * $urandom_range(0, 99);
            3:       y = 4 * $urandom_range(0, 2499);
            default: y = $urandom_range(0, 9999);
        endcase
        m   = (sel < 2 && $urandom_range(0, 1)) ? (sel == 0 ? 1 : 12) : $urandom_range(1, 12);
        len = date_scoreboard::days_in(y, m);
        sel = $urandom_range(0, 19);
        if (sel < 8)       d = len;
        else if (sel < 11) d = 1;
        else if (sel < 14) d = $urandom_range(len - 6, len);
        else               d = $urandom_range(1, len);
        r = make_req(OP_W'($urandom_range(OP_NEXT_DAY, OP_SNAP_MBEG_DN)), y, m, d);
        if (kind < 8) begin
            r = gds_req_t'($urandom);
        end else if (kind < 14) begin
            r.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end else if (kind < 20) begin
            case ($urandom_range(0, 3))
                0:       r.day_in   = DAY_W'(len + 1 > 31 ? 0 : len + 1);
                1:       r.day_in   = '0;
                2:       r.month_in = MONTH_W'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
                default: r.year_in  = YEAR_W'($urandom_range(10000, 16383));
            endcase
        end
        return r;
    endfunction

    task automatic send_request(gds_req_t r);
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    task automatic sender_gap(int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        sender_gap(1);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // response side: stall modes are picked at random, with one long hold-off
    initial begin
        int  mode;
        int  mode_left;
        int  hold_left;
        int  rsp_seen;
        bit  hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        rsp_seen  = 0;
        hold_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_response(m_rsp);
                rsp_seen++;
            end
            if (!hold_done && rsp_seen >= HOLD_AT_RSP) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= mode_left[2];
                endcase
            end
        end
    end

    initial begin
        gds_req_t directed[$];
        int       sent;
        int       burst;
        bit       drained;
        directed = '{
            make_req(OP_NEXT_DAY,     0,     1,  1),
            make_req(OP_PREV_DAY,     0,     1,  1),
            make_req(OP_NEXT_DAY,     9999, 12, 31),
            make_req(OP_PREV_DAY,     2000,  3,  1),
            make_req(OP_PREV_DAY,     1900,  3,  1),
            make_req(OP_NEXT_DAY,     2024,  2, 29),
            make_req(OP_NEXT_MBEGIN,  9999, 12,  5),
            make_req(OP_PREV_MBEGIN,  0,     1, 20),
            make_req(OP_NEXT_MEND,    2023, 12, 31),
            make_req(OP_NEXT_MEND,    2000,  1, 31),
            make_req(OP_PREV_MEND,    2100,  3, 15),
            make_req(OP_PREV_MEND,    1,     1,  1),
            make_req(OP_NEXT_WEEK,    9999, 12, 25),
            make_req(OP_NEXT_WEEK,    2400,  2, 25),
            make_req(OP_PREV_WEEK,    0,     1,  6),
            make_req(OP_PREV_WEEK,    1600,  3,  3),
            make_req(OP_SNAP_MEND_UP, 1900,  2,  1),
            make_req(OP_SNAP_MEND_DN, 2023,  4, 30),
            make_req(OP_SNAP_MEND_DN, 0,     1, 15),
            make_req(OP_SNAP_MBEG_UP, 9999, 12,  2),
            make_req(OP_SNAP_MBEG_UP, 2023,  6,  1),
            make_req(OP_SNAP_MBEG_DN, 5000,  7, 31),
            make_req(OP_SPARE_HI,     16383, 15, 31),
            make_req(OP_SPARE_LO,     1900,  2, 29),
            make_req(OP_NEXT_DAY,     2023,  0,  0),
            make_req(OP_NEXT_DAY,     2023,  4, 31)
        };
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_request(directed[i]);
            sender_gap($urandom_range(0, 1));
        end
        wait_drained();

        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_REQS) begin
            burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 12);
            for (int j = 0; j < burst && sent < RANDOM_REQS; j++) begin
                send_request(random_req());
                sent++;
            end
            if (!drained && sent >= DRAIN_AT_REQ) begin
                drained = 1'b1;
                wait_drained();
            end else begin
                sender_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
            end
        end
        wait_drained();
        repeat (12) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[gregorian_date_stepper_core] OK");
        end else begin
            $display("[gregorian_date_stepper_core] ERROR");
        end
        $finish;
    end

endmodule
